### hdl/shap_pkg.sv
package shap_pkg;

  localparam int HISTORY_DEPTH = 100;

  localparam int TEMP_W = 12;
  localparam int HUMI_W = 7;
  localparam int AGE_W  = 7;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 10;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_MIN_SPAN = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HUMI_MIN_SPAN = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PLOT_TOP      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PLOT_HEIGHT   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PLOT_LEFT     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_X_STEP        = 3'd5;

  localparam logic [9:0] TEMP_MIN_SPAN_RST = 10'd50;
  localparam logic [6:0] HUMI_MIN_SPAN_RST = 7'd10;
  localparam logic [7:0] PLOT_TOP_RST      = 8'd68;
  localparam logic [7:0] PLOT_HEIGHT_RST   = 8'd44;
  localparam logic [7:0] PLOT_LEFT_RST     = 8'd24;
  localparam logic [4:0] X_STEP_RST        = 5'd2;

  localparam logic [9:0]  ROW_MAX = 10'd1023;
  localparam logic [11:0] COL_MAX = 12'd4095;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic signed [TEMP_W-1:0] temp;
    logic [HUMI_W-1:0]        humi;
    logic [AGE_W-1:0]         age;
  } item_t;

  typedef struct packed {
    logic [9:0] temp_min_span;
    logic [6:0] humi_min_span;
    logic [7:0] plot_top;
    logic [7:0] plot_height;
    logic [7:0] plot_left;
    logic [4:0] x_step;
  } cfg_t;

  typedef struct packed {
    logic signed [11:0] temp_top;
    logic signed [11:0] temp_bottom;
    logic [7:0]         humi_top;
    logic [7:0]         humi_bottom;
    logic [11:0]        point_x;
    logic [9:0]         temp_y;
    logic [9:0]         humi_y;
  } result_t;

endpackage

### hdl/shap_ram.sv
module shap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/shap_front.sv
// two-entry item queue; decodes the op bit
module shap_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         op,
  input  logic signed [11:0]           temp_tenths,
  input  logic [6:0]                   humidity_pct,
  input  logic [6:0]                   point_age,
  output logic                         item_valid,
  output shap_pkg::item_t              item,
  input  logic                         item_take
);

  shap_pkg::item_t slot [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            do_push;
  logic            do_take;

  assign full       = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = slot[rd_ptr];
  assign do_push    = push && !full;
  assign do_take    = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        slot[wr_ptr].op   <= op ? shap_pkg::OP_QUERY : shap_pkg::OP_STORE;
        slot[wr_ptr].temp <= temp_tenths;
        slot[wr_ptr].humi <= humidity_pct;
        slot[wr_ptr].age  <= point_age;
        wr_ptr <= !wr_ptr;
      end
      if (do_take) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_take);
    end
  end

endmodule

### hdl/shap_back.sv
// executes one item at a time: ring write and rescan, or point lookup and division
module shap_back #(
  parameter int DEPTH = shap_pkg::HISTORY_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  shap_pkg::cfg_t    cfg,
  input  logic              item_valid,
  input  shap_pkg::item_t   item,
  output logic              item_take,
  output shap_pkg::result_t res,
  output logic              res_valid,
  input  logic              res_pop
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = (AW + 1 > shap_pkg::AGE_W) ? AW + 1 : shap_pkg::AGE_W;
  localparam int NW = 21;
  localparam int RW = shap_pkg::TEMP_W + shap_pkg::HUMI_W;
  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_DRAIN, ST_WIDEN, ST_WRAP, ST_READ,
    ST_MUL, ST_LOAD, ST_DIV, ST_ROW, ST_DONE
  } state_t;

  state_t state;

  logic [AW-1:0]    wp;
  logic [AW:0]      fill;
  logic [AW-1:0]    cnt;
  logic [AW-1:0]    idx;
  logic [CW-1:0]    age_q;
  logic             rd_act;
  logic             rd_ok;
  logic             first;

  logic signed [11:0] tmax, tmin;
  logic [6:0]         hmax, hmin;

  logic signed [11:0] temp_axis_max, temp_axis_min;
  logic [7:0]         humi_axis_max, humi_axis_min;

  logic [11:0] px;
  logic [9:0]  ty, hy;
  logic        ch;

  logic [19:0]        prod_ta;
  logic signed [21:0] prod_tb;
  logic [15:0]        prod_ha;
  logic signed [17:0] prod_hb;

  logic [NW-1:0] div_num;
  logic [NW-1:0] quo;
  logic [11:0]   rem;
  logic [11:0]   den;
  logic [4:0]    dcnt;

  // RAM
  logic             ram_we;
  logic [AW-1:0]    raddr;
  logic [RW-1:0]    rdata;

  assign item_take = (state == ST_IDLE) && item_valid;
  assign ram_we    = item_take && (item.op == shap_pkg::OP_STORE);
  assign raddr     = (state == ST_SCAN) ? cnt : idx;

  shap_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata ({item.temp, item.humi}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // never-written entries read as zero; the ring fills from entry 0 upwards
  logic signed [11:0] rt;
  logic [6:0]         rh;
  assign rt = rd_ok ? $signed(rdata[RW-1:shap_pkg::HUMI_W]) : 12'sd0;
  assign rh = rd_ok ? rdata[shap_pkg::HUMI_W-1:0] : 7'd0;

  // span widening
  logic signed [12:0] tdiff_ax;
  logic signed [12:0] thalf;
  logic signed [13:0] tmax_w, tmin_w;
  logic [7:0]         hdiff_ax;
  logic [7:0]         hhalf;
  logic signed [9:0]  hmax_w, hmin_w;

  always_comb begin
    tdiff_ax = 13'(tmax) - 13'(tmin);
    thalf    = 13'sd0;
    if (tdiff_ax < $signed({3'b0, cfg.temp_min_span})) begin
      thalf = ($signed({3'b0, cfg.temp_min_span}) - tdiff_ax) >>> 1;
    end
    tmax_w = 14'(tmax) + 14'(thalf);
    tmin_w = 14'(tmin) - 14'(thalf);
    hdiff_ax = {1'b0, hmax} - {1'b0, hmin};
    hhalf    = 8'd0;
    if (hdiff_ax < {1'b0, cfg.humi_min_span}) begin
      hhalf = ({1'b0, cfg.humi_min_span} - hdiff_ax) >> 1;
    end
    hmax_w = $signed({3'b0, hmax}) + $signed({2'b0, hhalf});
    hmin_w = $signed({3'b0, hmin}) - $signed({2'b0, hhalf});
  end

  // current axis spans and point offsets
  logic signed [12:0] tspan;
  logic signed [8:0]  hspan;
  logic signed [12:0] tdiff_pt;
  logic signed [8:0]  hdiff_pt;
  assign tspan    = 13'(temp_axis_max) - 13'(temp_axis_min);
  assign hspan    = $signed({1'b0, humi_axis_max}) - $signed({1'b0, humi_axis_min});
  assign tdiff_pt = 13'(temp_axis_max) - 13'(rt);
  assign hdiff_pt = $signed({1'b0, humi_axis_max}) - $signed({2'b0, rh});

  logic signed [22:0] num_t, num_h, num_sel;
  logic               span_pos;
  logic [11:0]        den_sel;
  assign num_t = $signed({3'b0, prod_ta}) + 23'(prod_tb);
  assign num_h = $signed({7'b0, prod_ha}) + 23'(prod_hb);
  always_comb begin
    if (!ch) begin
      num_sel  = num_t;
      span_pos = (tspan > 13'sd0);
      den_sel  = tspan[11:0];
    end else begin
      num_sel  = num_h;
      span_pos = (hspan > 9'sd0);
      den_sel  = {4'b0, hspan[7:0]};
    end
  end

  logic [12:0] rem_sh;
  assign rem_sh = {rem, div_num[NW-1]};

  logic [12:0] col;
  assign col = 13'(cfg.plot_left) + 13'(cfg.x_step) * 13'(item.age) + 13'd1;

  logic [AW:0] idx_sum;
  assign idx_sum = {1'b0, wp} + {1'b0, age_q[AW-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      wp            <= '0;
      fill          <= '0;
      rd_act        <= 1'b0;
      res_valid     <= 1'b0;
      temp_axis_max <= '0;
      temp_axis_min <= '0;
      humi_axis_max <= '0;
      humi_axis_min <= '0;
    end else begin
      rd_act <= (state == ST_SCAN);
      rd_ok  <= ({1'b0, raddr} < fill);
      if (res_pop && res_valid) begin
        res_valid <= 1'b0;
      end
      if (rd_act) begin
        if (first || rt > tmax) tmax <= rt;
        if (first || rt < tmin) tmin <= rt;
        if (first || rh > hmax) hmax <= rh;
        if (first || rh < hmin) hmin <= rh;
        first <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_take) begin
            if (item.op == shap_pkg::OP_STORE) begin
              if (fill != DEPTH_S) fill <= fill + 1'b1;
              wp    <= (wp == LAST) ? '0 : wp + 1'b1;
              cnt   <= '0;
              first <= 1'b1;
              px    <= '0;
              ty    <= '0;
              hy    <= '0;
              state <= ST_SCAN;
            end else begin
              age_q <= CW'(item.age);
              px    <= (col > 13'(shap_pkg::COL_MAX)) ? shap_pkg::COL_MAX : col[11:0];
              state <= ST_WRAP;
            end
          end
        end
        ST_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: state <= ST_WIDEN;
        ST_WIDEN: begin
          temp_axis_max <= (tmax_w > 14'sd2047) ? 12'sd2047 : tmax_w[11:0];
          temp_axis_min <= (tmin_w < -14'sd2048) ? -12'sd2048 : tmin_w[11:0];
          humi_axis_max <= (hmax_w > 10'sd255) ? 8'd255 : hmax_w[7:0];
          humi_axis_min <= (hmin_w < 10'sd0) ? 8'd0 : hmin_w[7:0];
          state <= ST_DONE;
        end
        ST_WRAP: begin
          if (age_q >= DEPTH_C) begin
            age_q <= age_q - DEPTH_C;
          end else begin
            idx   <= (idx_sum >= DEPTH_S) ? AW'(idx_sum - DEPTH_S) : idx_sum[AW-1:0];
            state <= ST_READ;
          end
        end
        ST_READ: state <= ST_MUL;
        ST_MUL: begin
          prod_ta <= cfg.plot_top * tspan[11:0];
          prod_tb <= tdiff_pt * $signed({1'b0, cfg.plot_height});
          prod_ha <= cfg.plot_top * hspan[7:0];
          prod_hb <= hdiff_pt * $signed({1'b0, cfg.plot_height});
          ch      <= 1'b0;
          state   <= ST_LOAD;
        end
        ST_LOAD: begin
          if (!span_pos || num_sel < 23'sd0) begin
            quo   <= span_pos ? '0 : NW'(cfg.plot_top);
            state <= ST_ROW;
          end else begin
            div_num <= num_sel[NW-1:0];
            den     <= den_sel;
            rem     <= '0;
            quo     <= '0;
            dcnt    <= 5'(NW - 1);
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem_sh >= {1'b0, den}) begin
            rem <= 12'(rem_sh - {1'b0, den});
            quo <= {quo[NW-2:0], 1'b1};
          end else begin
            rem <= rem_sh[11:0];
            quo <= {quo[NW-2:0], 1'b0};
          end
          div_num <= {div_num[NW-2:0], 1'b0};
          dcnt    <= dcnt - 1'b1;
          if (dcnt == 5'd0) begin
            state <= ST_ROW;
          end
        end
        ST_ROW: begin
          if (!ch) begin
            ty    <= (quo > NW'(shap_pkg::ROW_MAX)) ? shap_pkg::ROW_MAX : quo[9:0];
            ch    <= 1'b1;
            state <= ST_LOAD;
          end else begin
            hy    <= (quo > NW'(shap_pkg::ROW_MAX)) ? shap_pkg::ROW_MAX : quo[9:0];
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!res_valid) begin
            res.temp_top    <= temp_axis_max;
            res.temp_bottom <= temp_axis_min;
            res.humi_top    <= humi_axis_max;
            res.humi_bottom <= humi_axis_min;
            res.point_x     <= px;
            res.temp_y      <= ty;
            res.humi_y      <= hy;
            res_valid       <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_wp_range: assert property (@(posedge clk) disable iff (rst) wp <= LAST)
    else $error("write pointer beyond ring");
  a_temp_order: assert property (@(posedge clk) disable iff (rst)
    temp_axis_max >= temp_axis_min)
    else $error("temperature axis inverted");
  a_humi_order: assert property (@(posedge clk) disable iff (rst)
    humi_axis_max >= humi_axis_min)
    else $error("humidity axis inverted");
  a_div_den: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> den != 12'd0)
    else $error("division by zero span");

endmodule

### hdl/sensor_history_autoscale_plotter.sv
// channel   | ports                                              | handshake
// input     | op temp_tenths humidity_pct point_age             | push / full
// result    | temp_top temp_bottom humi_top humi_bottom          | pop / empty
//           | point_x temp_y humi_y                              |
// config    | cfg_we cfg_index cfg_wdata                         | write, no wait
//
// A store does one ring read per cycle for the rescan,
// then drain, widen and result load.
// A query takes 21 bit-serial divider steps per channel, skipped when the span is
// zero or the row is negative, plus one wrap step per DEPTH taken off the age.
// Reset: synchronous; ring entries read as zero until written, no clearing pass.
// Up to two items queue in front; a result waits in its register until popped.
module sensor_history_autoscale_plotter #(
  parameter int HISTORY_DEPTH = shap_pkg::HISTORY_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               op,
  input  logic signed [11:0] temp_tenths,
  input  logic [6:0]         humidity_pct,
  input  logic [6:0]         point_age,
  output logic               empty,
  input  logic               pop,
  output logic signed [11:0] temp_top,
  output logic signed [11:0] temp_bottom,
  output logic [7:0]         humi_top,
  output logic [7:0]         humi_bottom,
  output logic [11:0]        point_x,
  output logic [9:0]         temp_y,
  output logic [9:0]         humi_y,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [9:0]         cfg_wdata
);

  shap_pkg::cfg_t    cfg;
  shap_pkg::item_t   item;
  shap_pkg::result_t res;
  logic              item_valid;
  logic              item_take;
  logic              res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_min_span <= shap_pkg::TEMP_MIN_SPAN_RST;
      cfg.humi_min_span <= shap_pkg::HUMI_MIN_SPAN_RST;
      cfg.plot_top      <= shap_pkg::PLOT_TOP_RST;
      cfg.plot_height   <= shap_pkg::PLOT_HEIGHT_RST;
      cfg.plot_left     <= shap_pkg::PLOT_LEFT_RST;
      cfg.x_step        <= shap_pkg::X_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        shap_pkg::REG_TEMP_MIN_SPAN: cfg.temp_min_span <= cfg_wdata;
        shap_pkg::REG_HUMI_MIN_SPAN: cfg.humi_min_span <= cfg_wdata[6:0];
        shap_pkg::REG_PLOT_TOP:      cfg.plot_top      <= cfg_wdata[7:0];
        shap_pkg::REG_PLOT_HEIGHT:   cfg.plot_height   <= cfg_wdata[7:0];
        shap_pkg::REG_PLOT_LEFT:     cfg.plot_left     <= cfg_wdata[7:0];
        shap_pkg::REG_X_STEP:        cfg.x_step        <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  shap_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .temp_tenths  (temp_tenths),
    .humidity_pct (humidity_pct),
    .point_age    (point_age),
    .item_valid   (item_valid),
    .item         (item),
    .item_take    (item_take)
  );

  shap_back #(.DEPTH(HISTORY_DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res        (res),
    .res_valid  (res_valid),
    .res_pop    (pop)
  );

  assign empty       = !res_valid;
  assign temp_top    = res.temp_top;
  assign temp_bottom = res.temp_bottom;
  assign humi_top    = res.humi_top;
  assign humi_bottom = res.humi_bottom;
  assign point_x     = res.point_x;
  assign temp_y      = res.temp_y;
  assign humi_y      = res.humi_y;

endmodule
